>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Depends on nothing; the user provides clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define RWL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define RWL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/rwl_pkg.sv
// Package of the restart window limiter: payload structs, codes and
// controller/datapath handshake structs. Depends on nothing.
package rwl_pkg;

  localparam int TIME_W    = 48;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [TIME_W-1:0] now_ms;
    logic [1:0]        launch_kind;
    logic [2:0]        exit_kind;
    logic [1:0]        gate_outcome;
  } rwl_in_t;

  typedef struct packed {
    logic [1:0]  disposition;
    logic        restart_due;
    logic [4:0]  attempt_number;
    logic [31:0] wait_ms;
    logic [2:0]  life_state;
    logic [1:0]  gate_result_echo;
    logic        release_gate;
  } rwl_out_t;

  typedef enum logic [1:0] {
    REQ_STARTUP = 2'd0,
    REQ_EXIT    = 2'd1,
    REQ_RUNNING = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    DISP_ALLOW     = 2'd0,
    DISP_DENY_DUP  = 2'd1,
    DISP_DENY_SUPP = 2'd2,
    DISP_DELAY     = 2'd3
  } disp_t;

  typedef enum logic [2:0] {
    LS_IDLE       = 3'd0,
    LS_PENDING    = 3'd1,
    LS_SUPPRESSED = 3'd2,
    LS_APPROVED   = 3'd3,
    LS_RUNNING    = 3'd4
  } life_t;

  typedef enum logic [2:0] {
    CFG_RESTART_ENABLE = 3'd0,
    CFG_MAX_RESTARTS   = 3'd1,
    CFG_WINDOW_LENGTH  = 3'd2,
    CFG_MIN_BACKOFF    = 3'd3,
    CFG_MAX_BACKOFF    = 3'd4,
    CFG_BACKOFF_FACTOR = 3'd5,
    CFG_SINGLE_INST    = 3'd6
  } cfg_idx_t;

  localparam logic [2:0] EXIT_CRASH    = 3'd3;
  localparam logic [2:0] EXIT_WATCHDOG = 3'd4;
  localparam logic [2:0] EXIT_POLICY   = 3'd5;
  localparam logic [1:0] GATE_ACQUIRED = 2'd0;
  localparam logic [1:0] GATE_RUNNING  = 2'd1;
  localparam logic [1:0] LAUNCH_NORMAL = 2'd0;

  typedef struct packed {
    logic capture;
    logic setup;
    logic pop;
    logic decide;
    logic bo_mul;
    logic bo_chk;
    logic finish;
  } rwl_cmd_t;

  typedef struct packed {
    logic req_prunes;
    logic prune_more;
    logic bo_start;
    logic bo_last;
    logic out_free;
  } rwl_sts_t;

endpackage

>>> hw/rtl/rwl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module rwl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/rwl_ctrl.sv
// Sequencer of the restart window limiter: steps one item through setup,
// window pruning, decision, backoff iterations and result hand-off. Uses rwl_pkg.
module rwl_ctrl import rwl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output rwl_cmd_t cmd,
  input  rwl_sts_t sts
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_SETUP     = 8'b0000_0010,
    S_PRUNE_RD  = 8'b0000_0100,
    S_PRUNE_CMP = 8'b0000_1000,
    S_DECIDE    = 8'b0001_0000,
    S_BO_MUL    = 8'b0010_0000,
    S_BO_CHK    = 8'b0100_0000,
    S_FINISH    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.req_prunes ? S_SETUP : S_DECIDE;
        end
      end
      S_SETUP:     state_nxt = S_PRUNE_RD;
      S_PRUNE_RD:  state_nxt = S_PRUNE_CMP;
      S_PRUNE_CMP: state_nxt = sts.prune_more ? S_PRUNE_RD : S_DECIDE;
      S_DECIDE:    state_nxt = sts.bo_start ? S_BO_MUL : S_FINISH;
      S_BO_MUL:    state_nxt = S_BO_CHK;
      S_BO_CHK:    state_nxt = sts.bo_last ? S_FINISH : S_BO_MUL;
      S_FINISH: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall    = (state_r != S_IDLE);
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.setup   = (state_r == S_SETUP);
  assign cmd.pop     = (state_r == S_PRUNE_CMP) && sts.prune_more;
  assign cmd.decide  = (state_r == S_DECIDE);
  assign cmd.bo_mul  = (state_r == S_BO_MUL);
  assign cmd.bo_chk  = (state_r == S_BO_CHK);
  assign cmd.finish  = (state_r == S_FINISH) && sts.out_free;

endmodule

>>> hw/rtl/rwl_dp.sv
// Datapath of the restart window limiter: configuration registers, timestamp
// ring, counters, backoff multiplier and output register. Uses rwl_pkg, rwl_ram.
module rwl_dp import rwl_pkg::*; #(
  parameter int HISTORY_DEPTH    = 16,
  parameter int FACTOR_FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  rwl_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rwl_out_t             out_data,
  input  rwl_cmd_t             cmd,
  output rwl_sts_t             sts
);

  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam int SUM_W = CNT_W + 1;
  localparam int F     = FACTOR_FRAC_BITS;
  localparam int D_W   = 32 + F;
  localparam int P_W   = D_W + 16;
  localparam int N_W   = P_W - F;
  localparam int R_W   = D_W + 1 - F;

  // Configuration registers.
  logic        restart_enable_r;
  logic [4:0]  max_restarts_r;
  logic [31:0] window_r;
  logic [31:0] min_backoff_r;
  logic [31:0] max_backoff_r;
  logic [15:0] factor_r;
  logic        single_on_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_enable_r <= 1'b1;
      max_restarts_r   <= 5'd3;
      window_r         <= 32'd60000;
      min_backoff_r    <= 32'd1000;
      max_backoff_r    <= 32'd60000;
      factor_r         <= 16'd512;
      single_on_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RESTART_ENABLE: restart_enable_r <= cfg_wdata[0];
        CFG_MAX_RESTARTS:   max_restarts_r   <= cfg_wdata[4:0];
        CFG_WINDOW_LENGTH:  window_r         <= cfg_wdata;
        CFG_MIN_BACKOFF:    min_backoff_r    <= cfg_wdata;
        CFG_MAX_BACKOFF:    max_backoff_r    <= cfg_wdata;
        CFG_BACKOFF_FACTOR: factor_r         <= cfg_wdata[15:0];
        CFG_SINGLE_INST:    single_on_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Item and working registers.
  rwl_in_t           item_r;
  logic [TIME_W-1:0] floor_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  oldest_r, oldest_nxt;
  logic [2:0]        life_r;
  logic [1:0]        disp_r;
  logic              restart_r;
  logic [CNT_W-1:0]  attempt_r;
  logic [1:0]        echo_r;
  logic              release_r;
  logic [2:0]        lc_r;
  logic              bo_need_r;
  logic              start_bo_r;
  logic [D_W-1:0]    delay_r;
  logic [P_W-1:0]    prod_r;
  logic [CNT_W-1:0]  iter_r;
  logic              out_valid_r;
  rwl_out_t          out_r;

  // Timestamp ring.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [TIME_W-1:0] ram_rdata;

  rwl_ram #(
    .WIDTH (TIME_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (item_r.now_ms),
    .raddr (oldest_r),
    .rdata (ram_rdata)
  );

  // Limit, slot arithmetic and window floor.
  logic [CMP_W-1:0]  limit_w, count_ext;
  logic              at_limit;
  logic [SUM_W-1:0]  slot_sum;
  logic [TIME_W-1:0] window_ext;
  logic [TIME_W-1:0] floor_w;
  logic [IDX_W-1:0]  oldest_inc;

  always_comb begin
    limit_w = (CMP_W'(max_restarts_r) < CMP_W'(HISTORY_DEPTH)) ?
              CMP_W'(max_restarts_r) : CMP_W'(HISTORY_DEPTH);
    count_ext = CMP_W'(count_r);
    at_limit  = (count_ext >= limit_w);
    slot_sum  = SUM_W'(oldest_r) + SUM_W'(count_r);
    if (slot_sum >= SUM_W'(HISTORY_DEPTH)) begin
      slot_sum = slot_sum - SUM_W'(HISTORY_DEPTH);
    end
    ram_waddr  = slot_sum[IDX_W-1:0];
    window_ext = TIME_W'(window_r);
    floor_w    = (item_r.now_ms > window_ext) ? (item_r.now_ms - window_ext) : '0;
    oldest_inc = (oldest_r == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : oldest_r + 1'b1;
  end

  // Decision for the captured item, after pruning.
  logic             d_restart, d_release, d_bo, d_start_bo, d_record, d_clear;
  logic [1:0]       d_disp, d_echo;
  logic [2:0]       d_lc;
  logic [CNT_W-1:0] d_attempt;
  logic             candidate;

  always_comb begin
    d_disp     = DISP_ALLOW;
    d_restart  = 1'b0;
    d_release  = 1'b0;
    d_echo     = GATE_ACQUIRED;
    d_lc       = life_r;
    d_attempt  = '0;
    d_bo       = 1'b0;
    d_start_bo = 1'b0;
    d_record   = 1'b0;
    d_clear    = 1'b0;
    candidate  = (item_r.exit_kind == EXIT_CRASH) || (item_r.exit_kind == EXIT_WATCHDOG) ||
                 (item_r.exit_kind == EXIT_POLICY);
    unique case (item_r.req_type)
      REQ_STARTUP: begin
        if (single_on_r) begin
          d_echo = item_r.gate_outcome;
        end
        if (single_on_r && (item_r.gate_outcome != GATE_ACQUIRED)) begin
          d_disp = (item_r.gate_outcome == GATE_RUNNING) ? DISP_DENY_DUP : DISP_DENY_SUPP;
          d_lc   = LS_SUPPRESSED;
        end else if ((item_r.launch_kind != LAUNCH_NORMAL) && restart_enable_r) begin
          if (at_limit) begin
            d_disp = DISP_DENY_SUPP;
            d_lc   = LS_SUPPRESSED;
          end else begin
            d_attempt  = count_r + 1'b1;
            d_bo       = 1'b1;
            d_start_bo = 1'b1;
          end
        end else begin
          d_lc = LS_APPROVED;
        end
      end
      REQ_EXIT: begin
        d_release = 1'b1;
        if (!restart_enable_r || !candidate) begin
          d_lc = LS_IDLE;
        end else if (at_limit) begin
          d_lc = LS_SUPPRESSED;
        end else begin
          d_record  = 1'b1;
          d_attempt = count_r + 1'b1;
          d_restart = 1'b1;
          d_bo      = 1'b1;
          d_lc      = LS_PENDING;
        end
      end
      REQ_RUNNING: d_lc = LS_RUNNING;
      REQ_CLEAR:   d_clear = 1'b1;
      default: ;
    endcase
  end

  assign ram_we = cmd.decide && d_record;

  // Backoff iteration check.
  logic [N_W-1:0] next_delay;
  logic [N_W-1:0] cap_ext;
  logic           capped;
  logic [D_W-1:0] cap_w;

  always_comb begin
    cap_w      = {max_backoff_r, F'(0)};
    next_delay = prod_r[P_W-1:F];
    cap_ext    = N_W'(cap_w);
    capped     = (next_delay >= cap_ext);
  end

  // Rounding and clamping of the final backoff.
  logic [D_W:0]   round_sum;
  logic [R_W-1:0] whole;
  logic [31:0]    clamped, f_delay;
  logic [1:0]     f_disp;
  logic [2:0]     f_lc;
  logic [CMP_W-1:0] attempt_ext;

  always_comb begin
    round_sum = {1'b0, delay_r} + ((D_W+1)'(1) << (F - 1));
    whole     = round_sum[D_W:F];
    if (whole < R_W'(min_backoff_r)) begin
      clamped = min_backoff_r;
    end else if (whole > R_W'(max_backoff_r)) begin
      clamped = max_backoff_r;
    end else begin
      clamped = whole[31:0];
    end
    f_delay = bo_need_r ? clamped : 32'd0;
    f_disp  = disp_r;
    f_lc    = lc_r;
    if (start_bo_r) begin
      if (f_delay != 32'd0) begin
        f_disp = DISP_DELAY;
        f_lc   = LS_PENDING;
      end else begin
        f_disp = DISP_ALLOW;
        f_lc   = LS_APPROVED;
      end
    end
    attempt_ext = CMP_W'(attempt_r);
  end

  // Ring bookkeeping.
  always_comb begin
    count_nxt  = count_r;
    oldest_nxt = oldest_r;
    if (cmd.setup && (window_r == 32'd0)) begin
      count_nxt  = '0;
      oldest_nxt = '0;
    end else if (cmd.pop) begin
      count_nxt  = count_r - 1'b1;
      oldest_nxt = oldest_inc;
    end else if (cmd.decide && d_clear) begin
      count_nxt  = '0;
      oldest_nxt = '0;
    end else if (cmd.decide && d_record) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      oldest_r    <= '0;
      life_r      <= LS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      oldest_r <= oldest_nxt;
      if (cmd.finish) begin
        life_r      <= f_lc;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.setup) begin
      floor_r <= floor_w;
    end
    if (cmd.decide) begin
      disp_r     <= d_disp;
      restart_r  <= d_restart;
      attempt_r  <= d_attempt;
      echo_r     <= d_echo;
      release_r  <= d_release;
      lc_r       <= d_lc;
      bo_need_r  <= d_bo;
      start_bo_r <= d_start_bo;
      delay_r    <= {min_backoff_r, F'(0)};
      iter_r     <= CNT_W'(1);
    end
    if (cmd.bo_mul) begin
      prod_r <= P_W'(delay_r) * P_W'(factor_r);
    end
    if (cmd.bo_chk) begin
      delay_r <= capped ? cap_w : next_delay[D_W-1:0];
      iter_r  <= iter_r + 1'b1;
    end
    if (cmd.finish) begin
      out_r.disposition      <= f_disp;
      out_r.restart_due      <= restart_r;
      out_r.attempt_number   <= attempt_ext[4:0];
      out_r.wait_ms          <= f_delay;
      out_r.life_state       <= f_lc;
      out_r.gate_result_echo <= echo_r;
      out_r.release_gate     <= release_r;
    end
  end

  always_comb begin
    sts.req_prunes = (in_data.req_type == REQ_STARTUP) || (in_data.req_type == REQ_EXIT);
    sts.prune_more = (count_r != '0) && (ram_rdata < floor_r);
    sts.bo_start   = d_bo && (d_attempt > CNT_W'(1));
    sts.bo_last    = capped || ((iter_r + 1'b1) >= attempt_r);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hw/rtl/restart_window_limiter_backoff_top.sv
// Top level of the restart window limiter with exponential backoff.
// Depends on rwl_pkg, rwl_ctrl, rwl_dp (which holds rwl_ram).
//
// Usage. Software presents one request beat on the in_ channel (startup
// request, process exit, mark running or clear history) and receives exactly
// one result beat on the out_ channel. A beat moves when valid is high and
// stall is low. Configuration is written through cfg_we/cfg_index/cfg_wdata
// while the block is idle; writes to index seven are ignored.
//
// Sequence. Mark running and clear history go from accept through the decide
// step into the result register. Startup and exit requests first pass a setup
// step, then drop expired timestamps from the ring one at a time (each needs
// one registered RAM read and a compare), then decide and run the backoff
// multiply steps, at most attempt minus one. Each multiply step is a registered
// 40x16 product followed by a shift, compare and clamp against the cap.
// One item is in work at a time; the next is taken once the result has been
// moved into the output register, so a single stalled result does not block
// intake.
//
// Reset (synchronous, rst_n low) empties the ring, sets the lifecycle to idle,
// drops any held result and loads the configuration defaults. The ring RAM is
// not cleared; only entries written by recorded restarts are ever read. While
// out_stall is high the result holds steady and one further item may finish
// into the sequencer before intake stops.
module restart_window_limiter_backoff_top import rwl_pkg::*; #(
  parameter int HISTORY_DEPTH    = 16,
  parameter int FACTOR_FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rwl_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rwl_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Commands from the sequencer and status back from the datapath.
  rwl_cmd_t cmd;
  rwl_sts_t sts;

  rwl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  rwl_dp #(
    .HISTORY_DEPTH    (HISTORY_DEPTH),
    .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> hw/rtl/rwl_checker.sv
// Port-level checker for the restart window limiter, bound to the top level.
// Depends on rwl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rwl_checker import rwl_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input rwl_out_t out_data
);

  logic exit_clean, restart_ok, delay_ok;

  assign exit_clean = (out_data.disposition == DISP_ALLOW) &&
                      (out_data.gate_result_echo == GATE_ACQUIRED);
  assign restart_ok = out_data.release_gate && (out_data.attempt_number != 5'd0) &&
                      (out_data.life_state == LS_PENDING);
  assign delay_ok   = (out_data.wait_ms != 32'd0) && (out_data.life_state == LS_PENDING);

  // A held result must not move.
  `RWL_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "held beat changed")

  // Reset drops any pending result.
  `RWL_ASSERT_RST(a_reset_clear, !rst_n |=> !out_valid, "result valid after reset")

  // Exit events never carry a startup disposition or gate echo.
  `RWL_ASSERT(a_exit_fields, out_valid && out_data.release_gate |-> exit_clean, "exit beat mixed")

  // A scheduled restart is an exit with a nonzero attempt, pending.
  `RWL_ASSERT(a_restart_sched, out_valid && out_data.restart_due |-> restart_ok, "restart beat bad")

  // A delayed launch has a nonzero delay and leaves the lifecycle pending.
  `RWL_ASSERT(a_delay_pending, out_valid && out_data.disposition == DISP_DELAY |-> delay_ok, "delay bad")

endmodule

bind restart_window_limiter_backoff_top rwl_checker u_rwl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> verif/restart_window_limiter_backoff_top_tb.sv
// Self-checking testbench for restart_window_limiter_backoff_top.
// Depends on rwl_pkg and the RTL of the block; reads no files and needs no arguments.
// Runs directed corner cases first, then random traffic under several idle and stall mixes.
module restart_window_limiter_backoff_top_tb import rwl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = 16;
  localparam int FRAC      = 8;
  localparam int DOG_LIMIT = 20000;
  localparam int SETTLE    = 120;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  rwl_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  rwl_out_t out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  restart_window_limiter_backoff_top #(
    .HISTORY_DEPTH(DEPTH),
    .FACTOR_FRAC_BITS(FRAC)
  ) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the configuration registers, mirrored on every write.
  logic        sh_enable;
  logic [4:0]  sh_max_restarts;
  logic [31:0] sh_window;
  logic [31:0] sh_min_bo;
  logic [31:0] sh_max_bo;
  logic [15:0] sh_factor;
  logic        sh_single;

  // Shadow copy of the restart history and the lifecycle state.
  logic [TIME_W-1:0] stamp_hist [DEPTH];
  int unsigned       stamp_cnt;
  int unsigned       stamp_head;
  life_t             life_now;

  rwl_out_t    expected_results[$];
  int unsigned errors;
  int unsigned n_beats, n_results, n_delayed, n_suppressed, n_restarts;
  int unsigned idle_pct, stall_pct;
  int unsigned dog;
  logic [TIME_W-1:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side: stall pattern is redrawn at every falling edge so that
  // gaps land on every phase of the block's work.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog: any cycle without a moving beat on either channel counts up.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      dog <= 0;
    end else if (dog >= DOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      dog <= dog + 1;
    end
  end

  // Result checker: each accepted result beat is matched against the oldest
  // expectation. Reset is never reasserted; beats are checked only while rst_n is high.
  always @(posedge clk) begin
    rwl_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, actual %p", $time, out_data);
      end else begin
        want = expected_results.pop_front();
        if (out_data.disposition !== want.disposition)
          $display("%0t: disposition exp %0d act %0d", $time, want.disposition,
                   out_data.disposition);
        if (out_data.restart_due !== want.restart_due)
          $display("%0t: restart_due exp %0d act %0d", $time, want.restart_due,
                   out_data.restart_due);
        if (out_data.attempt_number !== want.attempt_number)
          $display("%0t: attempt_number exp %0d act %0d", $time, want.attempt_number,
                   out_data.attempt_number);
        if (out_data.wait_ms !== want.wait_ms)
          $display("%0t: wait_ms exp %0d act %0d", $time, want.wait_ms,
                   out_data.wait_ms);
        if (out_data.life_state !== want.life_state)
          $display("%0t: life_state exp %0d act %0d", $time, want.life_state,
                   out_data.life_state);
        if (out_data.gate_result_echo !== want.gate_result_echo)
          $display("%0t: gate_result_echo exp %0d act %0d", $time,
                   want.gate_result_echo, out_data.gate_result_echo);
        if (out_data.release_gate !== want.release_gate)
          $display("%0t: release_gate exp %0d act %0d", $time, want.release_gate,
                   out_data.release_gate);
        if (out_data !== want) errors++;
      end
    end
  end

  // Backoff for a given attempt: start at the minimum in 32.8 form, grow by the
  // factor once per further attempt, stop at the cap, round half up, clamp.
  function automatic logic [31:0] backoff_ms(int unsigned attempt);
    logic [63:0] acc, cap, whole;
    if (attempt == 0) return '0;
    acc = 64'(sh_min_bo) << FRAC;
    cap = 64'(sh_max_bo) << FRAC;
    for (int unsigned i = 1; i < attempt; i++) begin
      acc = (acc * 64'(sh_factor)) >> FRAC;
      if (acc >= cap) begin
        acc = cap;
        break;
      end
    end
    whole = (acc + (64'd1 << (FRAC - 1))) >> FRAC;
    if (whole < 64'(sh_min_bo)) whole = 64'(sh_min_bo);
    else if (whole > 64'(sh_max_bo)) whole = 64'(sh_max_bo);
    return whole[31:0];
  endfunction

  // Drop every stamp older than now minus the window; a zero window empties
  // the history outright.
  function automatic void prune_history(logic [TIME_W-1:0] now);
    logic [63:0] floor_ms;
    if (sh_window == 0) begin
      stamp_cnt  = 0;
      stamp_head = 0;
      return;
    end
    floor_ms = (64'(now) > 64'(sh_window)) ? 64'(now) - 64'(sh_window) : 64'd0;
    while (stamp_cnt > 0 && 64'(stamp_hist[stamp_head]) < floor_ms) begin
      stamp_head = (stamp_head + 1) % DEPTH;
      stamp_cnt--;
    end
  endfunction

  function automatic rwl_out_t supervise(rwl_in_t req);
    rwl_out_t    r;
    int unsigned limit;
    logic        denied, decided;
    r      = '0;
    limit  = (sh_max_restarts < DEPTH) ? sh_max_restarts : DEPTH;
    denied = 1'b0;
    case (req_t'(req.req_type))
      REQ_STARTUP: begin
        prune_history(req.now_ms);
        if (sh_single) begin
          r.gate_result_echo = req.gate_outcome;
          if (req.gate_outcome == GATE_RUNNING) begin
            r.disposition = DISP_DENY_DUP;
            life_now      = LS_SUPPRESSED;
            denied        = 1'b1;
          end else if (req.gate_outcome != GATE_ACQUIRED) begin
            r.disposition = DISP_DENY_SUPP;
            life_now      = LS_SUPPRESSED;
            denied        = 1'b1;
          end
        end
        if (!denied) begin
          decided = 1'b0;
          if (req.launch_kind != LAUNCH_NORMAL && sh_enable) begin
            if (stamp_cnt >= limit) begin
              r.disposition = DISP_DENY_SUPP;
              life_now      = LS_SUPPRESSED;
              decided       = 1'b1;
            end else begin
              r.attempt_number = 5'(stamp_cnt + 1);
              r.wait_ms        = backoff_ms(stamp_cnt + 1);
              if (r.wait_ms != 0) begin
                r.disposition = DISP_DELAY;
                life_now      = LS_PENDING;
                decided       = 1'b1;
              end
            end
          end
          if (!decided) begin
            r.disposition = DISP_ALLOW;
            life_now      = LS_APPROVED;
          end
        end
      end
      REQ_EXIT: begin
        r.release_gate = 1'b1;
        prune_history(req.now_ms);
        if (!sh_enable || !(req.exit_kind inside {EXIT_CRASH, EXIT_WATCHDOG, EXIT_POLICY}))
        begin
          life_now = LS_IDLE;
        end else if (stamp_cnt >= limit) begin
          life_now = LS_SUPPRESSED;
        end else begin
          stamp_hist[(stamp_head + stamp_cnt) % DEPTH] = req.now_ms;
          stamp_cnt++;
          r.attempt_number = 5'(stamp_cnt);
          r.restart_due    = 1'b1;
          r.wait_ms        = backoff_ms(stamp_cnt);
          life_now         = LS_PENDING;
        end
      end
      REQ_RUNNING: life_now = LS_RUNNING;
      default: begin
        stamp_cnt  = 0;
        stamp_head = 0;
      end
    endcase
    r.life_state = life_now;
    return r;
  endfunction

  // Sends one request beat, with random idle cycles first, and records the
  // expected result once the beat has been accepted.
  task automatic send_request(rwl_in_t req);
    rwl_out_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_data  <= rwl_in_t'({$urandom, $urandom, $urandom});
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    r = supervise(req);
    expected_results.insert(expected_results.size(), r);
    n_beats++;
    if (r.disposition == DISP_DELAY) n_delayed++;
    if (r.life_state == LS_SUPPRESSED) n_suppressed++;
    if (r.restart_due) n_restarts++;
  endtask

  // Waits until every result has arrived, then lets the block settle, since
  // the sequencer may still be finishing its last beat.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_RESTART_ENABLE: sh_enable       = value[0];
      CFG_MAX_RESTARTS:   sh_max_restarts = value[4:0];
      CFG_WINDOW_LENGTH:  sh_window       = value;
      CFG_MIN_BACKOFF:    sh_min_bo       = value;
      CFG_MAX_BACKOFF:    sh_max_bo       = value;
      CFG_BACKOFF_FACTOR: sh_factor       = value[15:0];
      default:            sh_single       = value[0];
    endcase
  endtask

  function automatic rwl_in_t make_req(req_t kind, logic [TIME_W-1:0] now, logic [1:0] launch,
                                       logic [2:0] exitk, logic [1:0] gate);
    rwl_in_t r;
    r.req_type     = kind;
    r.now_ms       = now;
    r.launch_kind  = launch;
    r.exit_kind    = exitk;
    r.gate_outcome = gate;
    return r;
  endfunction

  // Defaults after reset: a crash loop reaching the limit of three, the
  // denied startup that follows, a non-restart exit, the odd exit codes,
  // mark running, clear history and a step of time backwards.
  task automatic test_default_limits();
    send_request(make_req(REQ_STARTUP, 48'd0, LAUNCH_NORMAL, 3'd0, 2'd3));
    for (int i = 0; i < 4; i++)
      send_request(make_req(REQ_EXIT, 48'(100 + i), 2'd0, EXIT_CRASH + 3'(i % 3), 2'd0));
    send_request(make_req(REQ_STARTUP, 48'd110, 2'd2, 3'd0, 2'd0));
    send_request(make_req(REQ_EXIT, 48'd120, 2'd0, 3'd6, 2'd0));
    send_request(make_req(REQ_EXIT, 48'd130, 2'd0, 3'd7, 2'd0));
    send_request(make_req(REQ_RUNNING, 48'd140, 2'd3, 3'd1, 2'd1));
    send_request(make_req(REQ_EXIT, 48'd70000, 2'd0, EXIT_WATCHDOG, 2'd0));
    send_request(make_req(REQ_EXIT, 48'd50, 2'd0, EXIT_POLICY, 2'd0));
    send_request(make_req(REQ_CLEAR, 48'd60, 2'd1, 3'd2, 2'd2));
    send_request(make_req(REQ_STARTUP, 48'hFFFF_FFFF_FFFF, 2'd1, 3'd7, 2'd3));
    drain();
  endtask

  // Gate enforced: each gate outcome, including the undefined code three.
  task automatic test_instance_gate();
    write_reg(CFG_SINGLE_INST, 32'd1);
    for (int g = 0; g < 4; g++)
      send_request(make_req(REQ_STARTUP, 48'd200, 2'd1, 3'd0, 2'(g)));
    drain();
  endtask

  // Register extremes: zero and full-scale window, minimum above maximum,
  // factor zero and full scale, limit zero and above the history depth,
  // restart handling switched off.
  task automatic test_register_extremes();
    write_reg(CFG_SINGLE_INST, 32'd0);
    write_reg(CFG_WINDOW_LENGTH, 32'hFFFF_FFFF);
    write_reg(CFG_MAX_RESTARTS, 32'd31);
    write_reg(CFG_MIN_BACKOFF, 32'hFFFF_FFFF);
    write_reg(CFG_MAX_BACKOFF, 32'd5);
    write_reg(CFG_BACKOFF_FACTOR, 32'hFFFF);
    for (int i = 0; i < 3; i++)
      send_request(make_req(REQ_EXIT, 48'(1000 + i), 2'd0, EXIT_CRASH, 2'd0));
    drain();
    write_reg(CFG_MIN_BACKOFF, 32'd0);
    write_reg(CFG_MAX_BACKOFF, 32'hFFFF_FFFF);
    write_reg(CFG_BACKOFF_FACTOR, 32'd0);
    send_request(make_req(REQ_EXIT, 48'd2000, 2'd0, EXIT_WATCHDOG, 2'd0));
    send_request(make_req(REQ_STARTUP, 48'd2001, 2'd3, 3'd0, 2'd0));
    drain();
    write_reg(CFG_WINDOW_LENGTH, 32'd0);
    write_reg(CFG_MAX_RESTARTS, 32'd0);
    send_request(make_req(REQ_STARTUP, 48'd3000, 2'd2, 3'd0, 2'd0));
    drain();
    write_reg(CFG_RESTART_ENABLE, 32'd0);
    send_request(make_req(REQ_EXIT, 48'd4000, 2'd0, EXIT_CRASH, 2'd0));
    send_request(make_req(REQ_STARTUP, 48'd4001, 2'd1, 3'd0, 2'd0));
    drain();
  endtask

  function automatic logic [31:0] pick_value(logic [31:0] typical);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return typical;
    endcase
  endfunction

  // One random phase: fresh configuration, then mostly realistic crash and
  // relaunch sequences with a slowly moving clock, plus some noise.
  task automatic test_random_traffic(int unsigned in_idle, int unsigned out_hold,
                                     int unsigned count);
    rwl_in_t     req;
    logic [31:0] win;
    int unsigned pick;
    drain();
    write_reg(CFG_RESTART_ENABLE, 32'($urandom_range(0, 9) != 0));
    write_reg(CFG_MAX_RESTARTS, ($urandom_range(0, 4) == 0) ? $urandom_range(17, 31)
                                                          : $urandom_range(0, 16));
    win = pick_value($urandom_range(1, 5000));
    write_reg(CFG_WINDOW_LENGTH, win);
    write_reg(CFG_MIN_BACKOFF, pick_value($urandom_range(1, 2000)));
    write_reg(CFG_MAX_BACKOFF, pick_value($urandom_range(1000, 200000)));
    write_reg(CFG_BACKOFF_FACTOR, ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 65535))
                                                             : 32'($urandom_range(200, 800)));
    write_reg(CFG_SINGLE_INST, 32'($urandom_range(0, 1)));
    idle_pct  = in_idle;
    stall_pct = out_hold;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)
        clock_ms = 48'({$urandom, $urandom});
      else if (pick < 8)
        clock_ms = clock_ms - 48'($urandom_range(0, 3000));
      else
        clock_ms = clock_ms + 48'($urandom_range(0, (win != 0 && win < 5000) ? win / 2 : 3000));
      req              = rwl_in_t'({$urandom, $urandom, $urandom});
      req.now_ms       = clock_ms;
      pick             = $urandom_range(0, 99);
      if (pick < 50) begin
        req.req_type  = REQ_EXIT;
        if ($urandom_range(0, 3) != 0) req.exit_kind = EXIT_CRASH + 3'($urandom_range(0, 2));
      end else if (pick < 80) begin
        req.req_type = REQ_STARTUP;
        if ($urandom_range(0, 2) != 0) req.gate_outcome = GATE_ACQUIRED;
      end else if (pick < 93) begin
        req.req_type = REQ_RUNNING;
      end else begin
        req.req_type = REQ_CLEAR;
      end
      send_request(req);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    idle_pct  = 0;
    stall_pct = 0;
    dog       = 0;
    clock_ms  = '0;
    errors    = 0;
    n_beats = 0; n_results = 0; n_delayed = 0; n_suppressed = 0; n_restarts = 0;
    sh_enable = 1'b1; sh_max_restarts = 5'd3; sh_window = 32'd60000;
    sh_min_bo = 32'd1000; sh_max_bo = 32'd60000; sh_factor = 16'd512; sh_single = 1'b0;
    stamp_cnt = 0; stamp_head = 0; life_now = LS_IDLE;
    foreach (stamp_hist[i]) stamp_hist[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_limits();
    test_instance_gate();
    test_register_extremes();
    // Four traffic mixes: free flowing, sparse sender, busy receiver, both.
    for (int k = 0; k < 2; k++) begin
      test_random_traffic(0, 0, 120);
      test_random_traffic(64, 0, 120);
      test_random_traffic(0, 64, 120);
      test_random_traffic(31, 31, 120);
    end
    idle_pct  = 0;
    stall_pct = 0;
    drain();

    $display("Covered %0d request beats and %0d result beats over several register settings.",
             n_beats, n_results);
    $display("Delayed launches %0d, suppressed outcomes %0d, scheduled restarts %0d.",
             n_delayed, n_suppressed, n_restarts);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
